// File: hw/rtl/e2q_pkg.sv
// Shared constants, types and helpers for the Euler-angle to quaternion core.
// No dependencies; used by every module under hw/rtl.
package e2q_pkg;
    localparam int ANGLE_BITS = 16;
    localparam int OUT_BITS   = 16;
    localparam int TRIG_STEPS = 16;
    localparam int FRAC_BITS  = 30;
    localparam int PH_W       = 34;
    localparam int CS_W       = 33;
    localparam int PR_W       = 33;
    localparam int SUM_W      = 66;
    localparam logic signed [CS_W-1:0] GAIN_Q30 = 33'sd652032874;

    typedef logic signed [CS_W-1:0] cs_t;
    typedef logic signed [PH_W-1:0] ph_t;

    function automatic ph_t atan_k(input int i);
        logic [31:0] a;
        begin
            case (i)
                0: a = 32'h20000000;  1: a = 32'h12E4051E;  2: a = 32'h09FB385B;
                3: a = 32'h051111D4;  4: a = 32'h028B0D43;  5: a = 32'h0145D7E1;
                6: a = 32'h00A2F61E;  7: a = 32'h00517C55;  8: a = 32'h0028BE53;
                9: a = 32'h00145F2F; 10: a = 32'h000A2F98; 11: a = 32'h000517CC;
                12: a = 32'h00028BE6; 13: a = 32'h000145F3; 14: a = 32'h0000A2FA;
                15: a = 32'h0000517D; 16: a = 32'h000028BE; 17: a = 32'h0000145F;
                18: a = 32'h00000A30; 19: a = 32'h00000518; 20: a = 32'h0000028C;
                21: a = 32'h00000146; 22: a = 32'h000000A3; 23: a = 32'h00000051;
                24: a = 32'h00000029; 25: a = 32'h00000014; 26: a = 32'h0000000A;
                27: a = 32'h00000005; 28: a = 32'h00000003; 29: a = 32'h00000001;
                30: a = 32'h00000001;
                default: a = 32'h00000000;
            endcase
            atan_k = ph_t'({2'b00, a[30:0], 1'b0});
        end
    endfunction

    function automatic logic signed [OUT_BITS-1:0] quant(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        begin
            r = (v + (SUM_W'(1) <<< (60 - OUT_BITS))) >>> (61 - OUT_BITS);
            if (r > SUM_W'(2 ** (OUT_BITS - 1) - 1))
                quant = {1'b0, {(OUT_BITS-1){1'b1}}};
            else if (r < -SUM_W'(2 ** (OUT_BITS - 1)))
                quant = {1'b1, {(OUT_BITS-1){1'b0}}};
            else
                quant = r[OUT_BITS-1:0];
        end
    endfunction
endpackage

// File: hw/rtl/euler_to_quaternion_core.sv
// Euler angles (x, y, z binary angles) to unit quaternion in Q1.15.
// Input beat on s_valid/s_ready, result beat on m_valid/m_ready.
// Pipeline: TRIG_STEPS + 3 register stages (16 CORDIC stages, pair product,
// component product, round and saturate).
// Throughput: one beat per cycle while m_ready does not stall the output, set
// by the fully unrolled CORDIC lanes and the registered multiplier stages.
// The pipeline is a single stall domain: when m_valid is high and m_ready is
// low, every stage holds and s_ready drops; bubbles held in the pipe do not
// collapse.
// Reset (aresetn low, synchronous) clears all valid bits; data regs keep
// whatever they hold. No configuration, no state between beats.
// Depends on e2q_pkg, e2q_cordic, e2q_combine.
module euler_to_quaternion_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [e2q_pkg::ANGLE_BITS-1:0] s_angle_x,
    input  logic signed [e2q_pkg::ANGLE_BITS-1:0] s_angle_y,
    input  logic signed [e2q_pkg::ANGLE_BITS-1:0] s_angle_z,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [e2q_pkg::OUT_BITS-1:0]  m_quat_x,
    output logic signed [e2q_pkg::OUT_BITS-1:0]  m_quat_y,
    output logic signed [e2q_pkg::OUT_BITS-1:0]  m_quat_z,
    output logic signed [e2q_pkg::OUT_BITS-1:0]  m_quat_w
);
    localparam int LAT = e2q_pkg::TRIG_STEPS + 3;
    logic [LAT-1:0] vld_reg;
    logic adv;
    logic signed [e2q_pkg::ANGLE_BITS-1:0] ang [3];
    e2q_pkg::cs_t cs [3];
    e2q_pkg::cs_t sn [3];
    logic signed [e2q_pkg::OUT_BITS-1:0] q [4];

    assign m_valid = vld_reg[LAT-1];
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;
    assign ang[0]  = s_angle_x;
    assign ang[1]  = s_angle_y;
    assign ang[2]  = s_angle_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    e2q_cordic u_cordic (
        .aclk(aclk), .adv(adv), .ang(ang), .cos_o(cs), .sin_o(sn)
    );

    e2q_combine u_combine (.aclk(aclk), .adv(adv), .c(cs), .s(sn), .q(q));

    assign m_quat_x = q[0];
    assign m_quat_y = q[1];
    assign m_quat_z = q[2];
    assign m_quat_w = q[3];
endmodule

// File: hw/rtl/e2q_cordic.sv
// Unrolled rotation-mode CORDIC, one register stage per iteration, three lanes.
// Depends on e2q_pkg.
module e2q_cordic (
    input  logic                                     aclk,
    input  logic                                     adv,
    input  logic signed [e2q_pkg::ANGLE_BITS-1:0]    ang [3],
    output e2q_pkg::cs_t                             cos_o [3],
    output e2q_pkg::cs_t                             sin_o [3]
);
    localparam int N = e2q_pkg::TRIG_STEPS;
    e2q_pkg::cs_t x_reg [N+1][3];
    e2q_pkg::cs_t y_reg [N+1][3];
    e2q_pkg::ph_t z_reg [N+1][3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            x_reg[0][l] = e2q_pkg::GAIN_Q30;
            y_reg[0][l] = '0;
            z_reg[0][l] = {{(e2q_pkg::PH_W - 32){ang[l][e2q_pkg::ANGLE_BITS-1]}}, ang[l],
                           {(32 - e2q_pkg::ANGLE_BITS){1'b0}}};
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_st
        always_ff @(posedge aclk) begin
            if (adv) begin
                for (int l = 0; l < 3; l++) begin
                    if (!z_reg[i][l][e2q_pkg::PH_W-1]) begin
                        x_reg[i+1][l] <= x_reg[i][l] - (y_reg[i][l] >>> i);
                        y_reg[i+1][l] <= y_reg[i][l] + (x_reg[i][l] >>> i);
                        z_reg[i+1][l] <= z_reg[i][l] - e2q_pkg::atan_k(i);
                    end else begin
                        x_reg[i+1][l] <= x_reg[i][l] + (y_reg[i][l] >>> i);
                        y_reg[i+1][l] <= y_reg[i][l] - (x_reg[i][l] >>> i);
                        z_reg[i+1][l] <= z_reg[i][l] + e2q_pkg::atan_k(i);
                    end
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            cos_o[l] = x_reg[N][l];
            sin_o[l] = y_reg[N][l];
        end
    end
endmodule

// File: hw/rtl/e2q_combine.sv
// Pair products, then component products and sums with rounding and saturation.
// Depends on e2q_pkg.
module e2q_combine (
    input  logic                                  aclk,
    input  logic                                  adv,
    input  e2q_pkg::cs_t                          c [3],
    input  e2q_pkg::cs_t                          s [3],
    output logic signed [e2q_pkg::OUT_BITS-1:0]   q [4]
);
    localparam int W = e2q_pkg::SUM_W;
    logic signed [W-1:0] pp [4];
    logic signed [W-1:0] pp_reg [4];
    logic signed [e2q_pkg::PR_W-1:0] pr [4];
    e2q_pkg::cs_t cz_reg, sz_reg;
    logic signed [W-1:0] m_reg [8];
    logic signed [e2q_pkg::OUT_BITS-1:0] q_reg [4];

    always_comb begin
        pp[0] = W'(c[0]) * W'(c[1]);
        pp[1] = W'(s[0]) * W'(s[1]);
        pp[2] = W'(s[0]) * W'(c[1]);
        pp[3] = W'(c[0]) * W'(s[1]);
        for (int k = 0; k < 4; k++)
            pr[k] = e2q_pkg::PR_W'(pp_reg[k] >>> e2q_pkg::FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) pp_reg[k] <= pp[k];
            cz_reg  <= c[2];
            sz_reg  <= s[2];
            m_reg[0] <= W'(pr[2]) * W'(cz_reg);
            m_reg[1] <= W'(pr[3]) * W'(sz_reg);
            m_reg[2] <= W'(pr[3]) * W'(cz_reg);
            m_reg[3] <= W'(pr[2]) * W'(sz_reg);
            m_reg[4] <= W'(pr[0]) * W'(sz_reg);
            m_reg[5] <= W'(pr[1]) * W'(cz_reg);
            m_reg[6] <= W'(pr[0]) * W'(cz_reg);
            m_reg[7] <= W'(pr[1]) * W'(sz_reg);
            q_reg[0] <= e2q_pkg::quant(m_reg[0] - m_reg[1]);
            q_reg[1] <= e2q_pkg::quant(m_reg[2] + m_reg[3]);
            q_reg[2] <= e2q_pkg::quant(m_reg[4] - m_reg[5]);
            q_reg[3] <= e2q_pkg::quant(m_reg[6] + m_reg[7]);
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) q[k] = q_reg[k];
    end
endmodule
